FILE: sv/anp_pkg.sv
// ----------------------------------------------------------------------------
// anp_pkg
// Shared types, codes and digit decode for the ASCII number parser.
// ----------------------------------------------------------------------------
package anp_pkg;

  localparam int unsigned CountBitsDefault = 16;
  localparam int unsigned CharW            = 8;
  localparam int unsigned ValueW           = 64;
  localparam int unsigned HalfW            = 32;
  localparam int unsigned CharsW           = 16;
  localparam int unsigned RegIdxW          = 2;
  localparam int unsigned ProdW            = ValueW + 4;

  typedef enum logic [1:0] {
    ErrOk      = 2'd0,
    ErrNoDigit = 2'd1,
    ErrRange   = 2'd2
  } anp_err_e;

  typedef enum logic [RegIdxW-1:0] {
    RegRadixHex    = 2'd0,
    RegWidth64     = 2'd1,
    RegUseDefault  = 2'd2,
    RegDefaultVal  = 2'd3
  } anp_reg_e;

  typedef struct packed {
    logic              radix_hex;
    logic              width_64;
    logic              use_default;
    logic [ValueW-1:0] default_value;
  } anp_cfg_t;

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic [1:0]        error_code;
    logic [CharsW-1:0] chars_consumed;
  } anp_res_t;

  typedef struct packed {
    logic       is_digit;
    logic [3:0] digit;
  } anp_digit_t;

  function automatic anp_digit_t anp_decode(input logic [CharW-1:0] c, input logic hex);
    anp_digit_t r;
    r.is_digit = 1'b0;
    r.digit    = 4'd0;
    if (c inside {[8'h30:8'h39]}) begin
      r.is_digit = 1'b1;
      r.digit    = 4'(c - 8'h30);
    end else if (hex && (c inside {[8'h41:8'h46]})) begin
      r.is_digit = 1'b1;
      r.digit    = 4'(c - 8'h41 + 8'd10);
    end else if (hex && (c inside {[8'h61:8'h66]})) begin
      r.is_digit = 1'b1;
      r.digit    = 4'(c - 8'h61 + 8'd10);
    end
    return r;
  endfunction

endpackage

FILE: sv/anp_intf.sv
// ----------------------------------------------------------------------------
// anp_intf
// Valid/ready channels for characters, results and register writes.
// ----------------------------------------------------------------------------
interface anp_in_if import anp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CharW-1:0] char_code;
  logic             first_char;

  modport source (output valid, output char_code, output first_char, input ready);
  modport sink   (input valid, input char_code, input first_char, output ready);
endinterface

interface anp_out_if import anp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ValueW-1:0] value;
  logic [1:0]        error_code;
  logic [CharsW-1:0] chars_consumed;

  modport source (output valid, output value, output error_code, output chars_consumed,
                  input ready);
  modport sink   (input valid, input value, input error_code, input chars_consumed,
                  output ready);
endinterface

interface anp_cfg_if import anp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [RegIdxW-1:0] index;
  logic [ValueW-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: sv/ascii_number_parser_top.sv
// ----------------------------------------------------------------------------
// ascii_number_parser_top
// Streaming ASCII unsigned decimal/hex parser with exact range checking.
// ----------------------------------------------------------------------------
// One character word is taken every cycle while the output is not stalled.
// A word passes through an input register, then a single step of the parser
// (a multiply by ten or sixteen built from shifts and adds, plus the range
// compare) updates the running value and, at a terminator or an overflowing
// digit, loads the result register, which drives the output. The step loop
// of value, count and active flag sets the sustained rate of one character
// per cycle while the output is not stalled. Register writes are always
// accepted and apply from the next character on.
module ascii_number_parser_top import anp_pkg::*; #(
  parameter int unsigned COUNT_BITS = CountBitsDefault
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  anp_in_if.sink  in_i,
  anp_out_if.source out_o,
  anp_cfg_if.sink cfg_i
);

  anp_cfg_t              cfg_q;
  logic [ValueW-1:0]     acc_q, acc_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;
  logic                  active_q, active_d;

  logic                  s1_valid_q;
  logic [CharW-1:0]      s1_char_q;
  logic                  s1_first_q;
  logic                  s1_adv;

  logic                  out_valid_q;
  anp_res_t              out_q;
  logic                  out_free;

  logic                  emit;
  anp_res_t              res;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_i.valid) begin
      case (anp_reg_e'(cfg_i.index))
        RegRadixHex:   cfg_q.radix_hex     <= cfg_i.data[0];
        RegWidth64:    cfg_q.width_64      <= cfg_i.data[0];
        RegUseDefault: cfg_q.use_default   <= cfg_i.data[0];
        RegDefaultVal: cfg_q.default_value <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign out_free   = ~out_valid_q | out_o.ready;
  assign s1_adv     = s1_valid_q & out_free;
  assign in_i.ready = ~s1_valid_q | out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_char_q  <= in_i.char_code;
      s1_first_q <= in_i.first_char;
    end
  end

  anp_step #(
    .COUNT_BITS (COUNT_BITS)
  ) u_step (
    .char_code_i  (s1_char_q),
    .first_char_i (s1_first_q),
    .cfg_i        (cfg_q),
    .acc_i        (acc_q),
    .count_i      (cnt_q),
    .active_i     (active_q),
    .acc_o        (acc_d),
    .count_o      (cnt_d),
    .active_o     (active_d),
    .emit_o       (emit),
    .res_o        (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q    <= '0;
      cnt_q    <= '0;
      active_q <= 1'b0;
    end else if (s1_adv) begin
      acc_q    <= acc_d;
      cnt_q    <= cnt_d;
      active_q <= active_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_adv & emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && emit) begin
      out_q <= res;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.value          = out_q.value;
  assign out_o.error_code     = out_q.error_code;
  assign out_o.chars_consumed = out_q.chars_consumed;

  a_err_no_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_q.error_code != ErrOk) |-> out_q.chars_consumed == '0)
    else $error("error result with nonzero digit count");

  a_ok_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_q.error_code == ErrOk) && !cfg_q.width_64
    |-> out_q.value[ValueW-1:HalfW] == '0)
    else $error("ok result wider than 32 bits");

  a_idle_after_emit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && emit |=> !active_q)
    else $error("parser still active after a result");

  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |=> s1_valid_q && $stable(s1_char_q) && $stable(acc_q))
    else $error("stalled character or state changed");

endmodule

FILE: sv/anp_step.sv
// ----------------------------------------------------------------------------
// anp_step
// One parse step: folds a character into the running value and decides
// whether a result word leaves, with exact range checking.
// ----------------------------------------------------------------------------
module anp_step import anp_pkg::*; #(
  parameter int unsigned COUNT_BITS = CountBitsDefault
) (
  input  logic [CharW-1:0]      char_code_i,
  input  logic                  first_char_i,
  input  anp_cfg_t              cfg_i,
  input  logic [ValueW-1:0]     acc_i,
  input  logic [COUNT_BITS-1:0] count_i,
  input  logic                  active_i,
  output logic [ValueW-1:0]     acc_o,
  output logic [COUNT_BITS-1:0] count_o,
  output logic                  active_o,
  output logic                  emit_o,
  output anp_res_t              res_o
);

  localparam logic [COUNT_BITS-1:0] CountMax = '1;

  logic [ValueW-1:0]     acc_eff;
  logic [COUNT_BITS-1:0] cnt_eff;
  logic                  act;
  anp_digit_t            dig;
  logic [ProdW-1:0]      acc_ext;
  logic [ProdW-1:0]      next_val;
  logic                  over_new;
  logic                  over_old;
  logic [ValueW-1:0]     lim;
  logic [ValueW-1:0]     err_val;
  logic [31:0]           cnt_ext;
  logic [CharsW-1:0]     chars_sat;
  anp_err_e              err;

  assign acc_eff = first_char_i ? '0 : acc_i;
  assign cnt_eff = first_char_i ? '0 : count_i;
  assign act     = first_char_i | active_i;
  assign dig     = anp_decode(char_code_i, cfg_i.radix_hex);
  assign acc_ext = {4'd0, acc_eff};

  assign next_val = cfg_i.radix_hex
                  ? ((acc_ext << 4) + {{(ProdW-4){1'b0}}, dig.digit})
                  : ((acc_ext << 3) + (acc_ext << 1) + {{(ProdW-4){1'b0}}, dig.digit});

  assign over_new = cfg_i.width_64 ? (|next_val[ProdW-1:ValueW]) : (|next_val[ProdW-1:HalfW]);
  assign over_old = ~cfg_i.width_64 & (|acc_eff[ValueW-1:HalfW]);

  assign lim     = cfg_i.width_64 ? '1 : {{(ValueW-HalfW){1'b0}}, {HalfW{1'b1}}};
  assign err_val = cfg_i.use_default ? (cfg_i.default_value & lim) : '0;

  assign cnt_ext   = 32'(cnt_eff);
  assign chars_sat = (cnt_ext > 32'h0000_FFFF) ? '1 : cnt_ext[CharsW-1:0];

  always_comb begin
    acc_o    = acc_eff;
    count_o  = cnt_eff;
    active_o = act;
    emit_o   = 1'b0;
    err      = ErrOk;
    if (act) begin
      if (!dig.is_digit) begin
        emit_o   = 1'b1;
        active_o = 1'b0;
        if (cnt_eff == '0) begin
          err = ErrNoDigit;
        end else if (over_old) begin
          err = ErrRange;
        end
      end else if (over_new) begin
        emit_o   = 1'b1;
        active_o = 1'b0;
        err      = ErrRange;
      end else begin
        acc_o = next_val[ValueW-1:0];
        if (cnt_eff != CountMax) begin
          count_o = cnt_eff + 1'b1;
        end
      end
    end
  end

  always_comb begin
    res_o.error_code = err;
    if (err == ErrOk) begin
      res_o.value          = acc_eff;
      res_o.chars_consumed = chars_sat;
    end else begin
      res_o.value          = err_val;
      res_o.chars_consumed = '0;
    end
  end

endmodule
